### rtl/brl_pkg.sv
// Shared constants for the Bresenham line rasterizer.
// Holds configuration register indexes, widths and reset values; depends on nothing.
`default_nettype none

package brl_pkg;

    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 16;
    localparam int FRAME_DIM_BITS = 13;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_WIDTH  = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_HEIGHT = 8'd1;

    localparam logic [FRAME_DIM_BITS-1:0] FRAME_WIDTH_RESET  = 13'd640;
    localparam logic [FRAME_DIM_BITS-1:0] FRAME_HEIGHT_RESET = 13'd480;

    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_ADVANCE = 1'b1;

endpackage

`default_nettype wire

### rtl/brl_setup.sv
// Line setup logic: axis swap for steep lines, endpoint ordering and doubled deltas.
// Purely combinational; used by bresenham_line_rasterizer on a load request.
`default_nettype none

module brl_setup #(
    parameter int COORD_BITS = 16
) (
    input  wire logic signed [COORD_BITS-1:0] start_x,
    input  wire logic signed [COORD_BITS-1:0] start_y,
    input  wire logic signed [COORD_BITS-1:0] end_x,
    input  wire logic signed [COORD_BITS-1:0] end_y,
    output logic                              steep,
    output logic signed [COORD_BITS-1:0]      major_start,
    output logic signed [COORD_BITS-1:0]      major_stop,
    output logic signed [COORD_BITS-1:0]      minor_start,
    output logic                              minor_step_down,
    output logic [COORD_BITS+1:0]             major_delta2,
    output logic [COORD_BITS+1:0]             minor_delta2
);

    localparam int CB = COORD_BITS;

    logic [CB-1:0]        dx_abs;
    logic [CB-1:0]        dy_abs;
    logic [CB-1:0]        major_span;
    logic [CB-1:0]        minor_span;
    logic signed [CB-1:0] maj_a;
    logic signed [CB-1:0] maj_b;
    logic signed [CB-1:0] min_a;
    logic signed [CB-1:0] min_b;
    logic signed [CB:0]   maj_diff;
    logic signed [CB:0]   min_diff;

    function automatic logic [CB-1:0] abs_diff(input logic signed [CB-1:0] a,
                                               input logic signed [CB-1:0] b);
        logic signed [CB:0] d;
        d = (a > b) ? (CB+1)'(a) - (CB+1)'(b) : (CB+1)'(b) - (CB+1)'(a);
        return d[CB-1:0];
    endfunction

    always_comb begin
        dx_abs = abs_diff(start_x, end_x);
        dy_abs = abs_diff(start_y, end_y);
        steep  = dx_abs < dy_abs;

        maj_a = steep ? start_y : start_x;
        min_a = steep ? start_x : start_y;
        maj_b = steep ? end_y   : end_x;
        min_b = steep ? end_x   : end_y;

        if (maj_a > maj_b) begin
            major_start = maj_b;
            major_stop  = maj_a;
            minor_start = min_b;
            min_diff    = (CB+1)'(min_a) - (CB+1)'(min_b);
        end else begin
            major_start = maj_a;
            major_stop  = maj_b;
            minor_start = min_a;
            min_diff    = (CB+1)'(min_b) - (CB+1)'(min_a);
        end

        maj_diff        = (CB+1)'(major_stop) - (CB+1)'(major_start);
        minor_step_down = min_diff <= 0;
        major_span      = maj_diff[CB-1:0];
        minor_span      = minor_step_down ? CB'(-min_diff) : min_diff[CB-1:0];
        major_delta2    = {1'b0, major_span, 1'b0};
        minor_delta2    = {1'b0, minor_span, 1'b0};
    end

endmodule

`default_nettype wire

### rtl/bresenham_line_rasterizer.sv
// Bresenham line rasterizer top level: request handshakes, line state and pixel output.
// Depends on brl_pkg and brl_setup.
// A load request (tuser 0) latches two endpoints and a color and gives no pixel; each advance
// request (tuser 1) of an active line gives one pixel with its coordinates, color, an on-screen
// flag against frame_width/frame_height and tlast on the final pixel. Advance with no active
// line is absorbed without output. The block takes one request per clock while the output
// register is empty or being drained: the error add and compare runs from the line state
// registers straight into the output register.
// frame_width and frame_height sit at config indexes 0 and 1; write them only while idle.
`default_nettype none

module bresenham_line_rasterizer #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // start_x, start_y, end_x, end_y, line_color from bit 0, zero padded
    input  wire logic [((4*COORD_BITS+39)/8)*8-1:0] s_axis_tdata,
    // kind
    input  wire logic                            s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // pixel_x, pixel_y, pixel_color from bit 0, zero padded
    output logic [((2*COORD_BITS+39)/8)*8-1:0]   m_axis_tdata,
    // on_screen
    output logic                                 m_axis_tuser,
    output logic                                 m_axis_tlast,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [brl_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [brl_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    import brl_pkg::*;

    localparam int CB          = COORD_BITS;
    localparam int M_DATA_BITS = ((2*CB+39)/8)*8;
    localparam int CMP_BITS    = CB + FRAME_DIM_BITS + 1;

    logic [FRAME_DIM_BITS-1:0] frame_width_reg;
    logic [FRAME_DIM_BITS-1:0] frame_height_reg;

    logic                 active_reg, active_next;
    logic                 steep_reg, steep_next;
    logic signed [CB-1:0] major_pos_reg, major_pos_next;
    logic signed [CB-1:0] major_stop_reg, major_stop_next;
    logic signed [CB-1:0] minor_pos_reg, minor_pos_next;
    logic                 step_down_reg, step_down_next;
    logic [CB+2:0]        error_acc_reg, error_acc_next;
    logic [CB+1:0]        major_delta2_reg, major_delta2_next;
    logic [CB+1:0]        minor_delta2_reg, minor_delta2_next;
    logic [31:0]          held_color_reg, held_color_next;

    logic                 m_valid_reg, m_valid_next;
    logic signed [CB-1:0] px_reg, py_reg;
    logic [31:0]          color_reg;
    logic                 on_screen_reg, last_reg;

    logic                 s_fire;
    logic                 load_fire;
    logic                 adv_fire;
    logic                 setup_steep;
    logic signed [CB-1:0] setup_major_start;
    logic signed [CB-1:0] setup_major_stop;
    logic signed [CB-1:0] setup_minor_start;
    logic                 setup_step_down;
    logic [CB+1:0]        setup_major_delta2;
    logic [CB+1:0]        setup_minor_delta2;

    logic signed [CB-1:0]       px_now, py_now;
    logic                       last_now, vis_now;
    logic signed [CMP_BITS-1:0] px_ext, py_ext, fw_ext, fh_ext;
    logic [CB+2:0]              err_sum;

    brl_setup #(
        .COORD_BITS(CB)
    ) u_setup (
        .start_x        ($signed(s_axis_tdata[CB-1:0])),
        .start_y        ($signed(s_axis_tdata[2*CB-1:CB])),
        .end_x          ($signed(s_axis_tdata[3*CB-1:2*CB])),
        .end_y          ($signed(s_axis_tdata[4*CB-1:3*CB])),
        .steep          (setup_steep),
        .major_start    (setup_major_start),
        .major_stop     (setup_major_stop),
        .minor_start    (setup_minor_start),
        .minor_step_down(setup_step_down),
        .major_delta2   (setup_major_delta2),
        .minor_delta2   (setup_minor_delta2)
    );

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign load_fire     = s_fire && (s_axis_tuser == KIND_LOAD);
    assign adv_fire      = s_fire && (s_axis_tuser == KIND_ADVANCE) && active_reg;

    always_comb begin
        px_now   = steep_reg ? minor_pos_reg : major_pos_reg;
        py_now   = steep_reg ? major_pos_reg : minor_pos_reg;
        last_now = major_pos_reg == major_stop_reg;
        px_ext   = CMP_BITS'(px_now);
        py_ext   = CMP_BITS'(py_now);
        fw_ext   = $signed(CMP_BITS'(frame_width_reg));
        fh_ext   = $signed(CMP_BITS'(frame_height_reg));
        vis_now  = (px_ext >= 0) && (px_ext < fw_ext) && (py_ext >= 0) && (py_ext < fh_ext);
        err_sum  = error_acc_reg + (CB+3)'(minor_delta2_reg);
    end

    always_comb begin
        active_next       = active_reg;
        steep_next        = steep_reg;
        major_pos_next    = major_pos_reg;
        major_stop_next   = major_stop_reg;
        minor_pos_next    = minor_pos_reg;
        step_down_next    = step_down_reg;
        error_acc_next    = error_acc_reg;
        major_delta2_next = major_delta2_reg;
        minor_delta2_next = minor_delta2_reg;
        held_color_next   = held_color_reg;
        m_valid_next      = m_valid_reg && !m_axis_tready;

        priority if (load_fire) begin
            active_next       = 1'b1;
            steep_next        = setup_steep;
            major_pos_next    = setup_major_start;
            major_stop_next   = setup_major_stop;
            minor_pos_next    = setup_minor_start;
            step_down_next    = setup_step_down;
            error_acc_next    = '0;
            major_delta2_next = setup_major_delta2;
            minor_delta2_next = setup_minor_delta2;
            held_color_next   = s_axis_tdata[4*CB+31:4*CB];
        end else if (adv_fire) begin
            m_valid_next = 1'b1;
            if (err_sum >= (CB+3)'(major_delta2_reg)) begin
                minor_pos_next = step_down_reg ? minor_pos_reg - CB'(1) : minor_pos_reg + CB'(1);
                error_acc_next = err_sum - (CB+3)'(major_delta2_reg);
            end else begin
                error_acc_next = err_sum;
            end
            if (last_now) begin
                active_next = 1'b0;
            end else begin
                major_pos_next = major_pos_reg + CB'(1);
            end
        end else begin
            active_next = active_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
            active_reg       <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            active_reg  <= active_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_FRAME_WIDTH) begin
                    frame_width_reg <= cfg_data[FRAME_DIM_BITS-1:0];
                end
                if (cfg_index == CFG_FRAME_HEIGHT) begin
                    frame_height_reg <= cfg_data[FRAME_DIM_BITS-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        steep_reg        <= steep_next;
        major_pos_reg    <= major_pos_next;
        major_stop_reg   <= major_stop_next;
        minor_pos_reg    <= minor_pos_next;
        step_down_reg    <= step_down_next;
        error_acc_reg    <= error_acc_next;
        major_delta2_reg <= major_delta2_next;
        minor_delta2_reg <= minor_delta2_next;
        held_color_reg   <= held_color_next;
        if (adv_fire) begin
            px_reg        <= px_now;
            py_reg        <= py_now;
            color_reg     <= held_color_reg;
            on_screen_reg <= vis_now;
            last_reg      <= last_now;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = M_DATA_BITS'({color_reg, py_reg, px_reg});
    assign m_axis_tuser  = on_screen_reg;
    assign m_axis_tlast  = last_reg;

    // retire the line after its final pixel
    a_last_retires: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv_fire && last_now) |=> !active_reg)
        else $error("line still active after final pixel");

    a_load_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        load_fire |=> (active_reg && error_acc_reg == '0))
        else $error("load did not start a fresh line");

    a_error_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (active_reg && major_delta2_reg != '0) |->
            (error_acc_reg < (CB+3)'(major_delta2_reg)))
        else $error("error term out of range");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> m_valid_reg)
        else $error("input stalled with empty output register");

    a_idle_advance_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_axis_tuser == KIND_ADVANCE && !active_reg && !(m_valid_reg && !m_axis_tready))
            |=> !m_valid_reg)
        else $error("pixel emitted with no active line");

endmodule

`default_nettype wire
